@@ rtl/rfos_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfos_pkg
// Shared types, constants and helpers for the ring FIFO with overwrite and
// byte-prefix search.
// ----------------------------------------------------------------------------
package rfos_pkg;

	// Built geometry
	localparam int DEPTH       = 16;
	localparam int ENTRY_BYTES = 8;
	localparam int DATA_W      = 64;
	localparam int IDX_W       = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int MLEN_W      = 4;
	localparam int STAT_W      = 3;

	// Configuration port
	localparam int APB_DW = 32;
	localparam int ADDR_W = 3;
	localparam logic REG_MODE     = 1'b0;
	localparam logic REG_CAPACITY = 1'b1;
	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_FIND  = 2'd2,
		OP_DRAIN = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_WRITTEN  = 3'd0,
		ST_DROPPED  = 3'd1,
		ST_REJECTED = 3'd2,
		ST_READ_OK  = 3'd3,
		ST_EMPTY    = 3'd4,
		ST_MATCH    = 3'd5,
		ST_DONE     = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_FIND,
		BK_DRAIN
	} bk_state_t;

	// Classified item as it travels from front to back
	typedef struct packed {
		op_t               op;
		logic [DATA_W-1:0] data;
		logic [DATA_W-1:0] mask;
	} cmd_t;

	// One result item
	typedef struct packed {
		status_t           status;
		logic [DATA_W-1:0] data;
		logic [IDX_W-1:0]  position;
		logic [CNT_W-1:0]  count;
		logic              last;
	} res_t;

	// Configuration as seen by the back end
	typedef struct packed {
		logic             mode;
		logic [CNT_W-1:0] cap;
		logic             clear;
	} cfg_t;

	// Mask covering the low n bytes of an entry
	function automatic logic [DATA_W-1:0] byte_mask(input logic [MLEN_W-1:0] n);
		logic [DATA_W-1:0] m;
		m = '0;
		for (int b = 0; b < DATA_W / 8; b++) begin
			if (MLEN_W'(b) < n) begin
				m[b*8 +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage

@@ rtl/rfos_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfos_front
// Accepts input items, classifies them (operation, entry width, compare mask)
// and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rfos_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   operation,
	input  logic [rfos_pkg::DATA_W-1:0]  data,
	input  logic [rfos_pkg::MLEN_W-1:0]  match_len,
	output logic                         q_valid,
	output rfos_pkg::cmd_t               q_cmd,
	input  logic                         q_pop
);

	localparam logic [rfos_pkg::MLEN_W-1:0] MAX_LEN = rfos_pkg::MLEN_W'(rfos_pkg::ENTRY_BYTES);

	rfos_pkg::cmd_t    slot_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        fill_q;
	rfos_pkg::cmd_t    cmd_c;
	logic [rfos_pkg::MLEN_W-1:0] len_c;
	logic              push;

	// Classify: clamp the compare length, keep only the entry bytes
	always_comb begin
		len_c      = (match_len > MAX_LEN) ? MAX_LEN : match_len;
		cmd_c.op   = rfos_pkg::op_t'(operation);
		cmd_c.data = data & rfos_pkg::byte_mask(MAX_LEN);
		cmd_c.mask = rfos_pkg::byte_mask(len_c);
	end

	assign in_ready = (fill_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (fill_q != 2'd0);
	assign q_cmd    = slot_q[rd_ptr_q];

	// Queue payload
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cmd_c;
		end
	end

	// Queue pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, q_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

@@ rtl/rfos_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfos_back
// Executes queued items against the entry store: write and read, and find and
// drain at one entry per cycle while the output register is free; results go into an output register.
// ----------------------------------------------------------------------------
module rfos_back (
	input  logic           clk,
	input  logic           arst_n,
	input  rfos_pkg::cfg_t cfg,
	input  logic           q_valid,
	input  rfos_pkg::cmd_t q_cmd,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output rfos_pkg::res_t res
);

	localparam int IW = rfos_pkg::IDX_W;
	localparam int CW = rfos_pkg::CNT_W;

	// Next ring index, wrapping at the effective capacity
	function automatic logic [IW-1:0] adv(input logic [IW-1:0] i, input logic [CW-1:0] c);
		logic [CW-1:0] n;
		n = CW'(i) + CW'(1);
		return (n >= c) ? '0 : n[IW-1:0];
	endfunction

	logic [rfos_pkg::DATA_W-1:0] store_q [rfos_pkg::DEPTH];

	rfos_pkg::bk_state_t state_q, state_d;
	logic [IW-1:0]  rd_idx_q, rd_idx_d;
	logic [IW-1:0]  wr_idx_q, wr_idx_d;
	logic [CW-1:0]  fill_q, fill_d;
	logic [IW-1:0]  walk_q, walk_d;
	logic [CW-1:0]  step_q, step_d;
	logic [CW-1:0]  tally_q, tally_d;
	rfos_pkg::cmd_t cmd_q;
	logic           ov_q;
	rfos_pkg::res_t res_q;

	logic           out_free;
	logic           emit;
	rfos_pkg::res_t res_c;
	logic           we;
	logic [IW-1:0]  raddr;
	logic [rfos_pkg::DATA_W-1:0] rdata;
	logic           hit;

	assign out_free = !ov_q || out_ready;

	// Store read port: walk pointer during find, read pointer otherwise
	assign raddr = (state_q == rfos_pkg::BK_FIND) ? walk_q : rd_idx_q;
	assign rdata = store_q[raddr];
	assign hit   = ((rdata ^ cmd_q.data) & cmd_q.mask) == '0;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rfos_pkg::BK_IDLE: begin
				if (q_valid && out_free && fill_q != '0) begin
					if (q_cmd.op == rfos_pkg::OP_FIND) begin
						state_d = rfos_pkg::BK_FIND;
					end else if (q_cmd.op == rfos_pkg::OP_DRAIN) begin
						state_d = rfos_pkg::BK_DRAIN;
					end
				end
			end
			rfos_pkg::BK_FIND: begin
				if (out_free && step_q == fill_q) begin
					state_d = rfos_pkg::BK_IDLE;
				end
			end
			rfos_pkg::BK_DRAIN: begin
				if (out_free && fill_q == '0) begin
					state_d = rfos_pkg::BK_IDLE;
				end
			end
			default: state_d = rfos_pkg::BK_IDLE;
		endcase
	end

	// Datapath and results
	always_comb begin
		q_pop    = 1'b0;
		emit     = 1'b0;
		we       = 1'b0;
		res_c    = '{status: rfos_pkg::ST_EMPTY, data: '0, position: '0, count: '0,
			last: 1'b1};
		rd_idx_d = rd_idx_q;
		wr_idx_d = wr_idx_q;
		fill_d   = fill_q;
		walk_d   = walk_q;
		step_d   = step_q;
		tally_d  = tally_q;
		unique case (state_q)
			rfos_pkg::BK_IDLE: begin
				if (q_valid && out_free) begin
					q_pop = 1'b1;
					unique case (q_cmd.op)
						rfos_pkg::OP_WRITE: begin
							emit = 1'b1;
							if (fill_q >= cfg.cap && !cfg.mode) begin
								res_c.status = rfos_pkg::ST_REJECTED;
							end else begin
								we       = 1'b1;
								wr_idx_d = adv(wr_idx_q, cfg.cap);
								if (fill_q >= cfg.cap) begin
									res_c.status = rfos_pkg::ST_DROPPED;
									rd_idx_d     = adv(rd_idx_q, cfg.cap);
								end else begin
									res_c.status = rfos_pkg::ST_WRITTEN;
									fill_d       = fill_q + CW'(1);
								end
							end
						end
						rfos_pkg::OP_READ: begin
							emit = 1'b1;
							if (fill_q != '0) begin
								res_c.status = rfos_pkg::ST_READ_OK;
								res_c.data   = rdata;
								rd_idx_d     = adv(rd_idx_q, cfg.cap);
								fill_d       = fill_q - CW'(1);
							end
						end
						rfos_pkg::OP_FIND: begin
							walk_d  = rd_idx_q;
							step_d  = '0;
							tally_d = '0;
							if (fill_q == '0) begin
								emit         = 1'b1;
								res_c.status = rfos_pkg::ST_DONE;
							end
						end
						rfos_pkg::OP_DRAIN: begin
							tally_d = '0;
							if (fill_q == '0) begin
								emit = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			rfos_pkg::BK_FIND: begin
				if (out_free) begin
					if (step_q == fill_q) begin
						emit         = 1'b1;
						res_c.status = rfos_pkg::ST_DONE;
						res_c.count  = tally_q;
					end else begin
						if (hit) begin
							emit           = 1'b1;
							res_c.status   = rfos_pkg::ST_MATCH;
							res_c.data     = rdata;
							res_c.position = step_q[IW-1:0];
							res_c.last     = 1'b0;
							tally_d        = tally_q + CW'(1);
						end
						step_d = step_q + CW'(1);
						walk_d = adv(walk_q, cfg.cap);
					end
				end
			end
			rfos_pkg::BK_DRAIN: begin
				if (out_free) begin
					emit = 1'b1;
					if (fill_q == '0) begin
						res_c.count = tally_q;
					end else begin
						res_c.status = rfos_pkg::ST_READ_OK;
						res_c.data   = rdata;
						res_c.last   = 1'b0;
						rd_idx_d     = adv(rd_idx_q, cfg.cap);
						fill_d       = fill_q - CW'(1);
						tally_d      = tally_q + CW'(1);
					end
				end
			end
			default: ;
		endcase
	end

	// Entry store
	always_ff @(posedge clk) begin
		if (we) begin
			store_q[wr_idx_q] <= q_cmd.data;
		end
	end

	// Latched key and mask for the walk; result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
		if (emit) begin
			res_q <= res_c;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rfos_pkg::BK_IDLE;
			rd_idx_q <= '0;
			wr_idx_q <= '0;
			fill_q   <= '0;
			walk_q   <= '0;
			step_q   <= '0;
			tally_q  <= '0;
			ov_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			walk_q  <= walk_d;
			step_q  <= step_d;
			tally_q <= tally_d;
			if (cfg.clear) begin
				rd_idx_q <= '0;
				wr_idx_q <= '0;
				fill_q   <= '0;
			end else begin
				rd_idx_q <= rd_idx_d;
				wr_idx_q <= wr_idx_d;
				fill_q   <= fill_d;
			end
			if (emit) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign out_valid = ov_q;
	assign res       = res_q;

endmodule

@@ rtl/ring_fifo_overwrite_search_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_fifo_overwrite_search_core
// Circular FIFO with drop-oldest option and byte-prefix search; APB registers
// for mode and capacity.
// ----------------------------------------------------------------------------
// Path: with the back end idle, a write or read, or an empty find or drain,
//   passes the front queue and output register; a walk enters its state first.
// Throughput: write and read one item per cycle while the output is free;
//   find and drain one stored entry per cycle, also while the output is free.
// Reset: FIFO empty, indices zero, mode 0, capacity 16; entries are not cleared.
// ----------------------------------------------------------------------------
module ring_fifo_overwrite_search_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// APB configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rfos_pkg::ADDR_W-1:0]   paddr,
	input  logic [rfos_pkg::APB_DW-1:0]   pwdata,
	output logic [rfos_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	// Input items
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    operation,
	input  logic [rfos_pkg::DATA_W-1:0]   data,
	input  logic [rfos_pkg::MLEN_W-1:0]   match_len,
	// Result items
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rfos_pkg::STAT_W-1:0]   status,
	output logic [rfos_pkg::DATA_W-1:0]   entry_data,
	output logic [rfos_pkg::IDX_W-1:0]    position,
	output logic [rfos_pkg::CNT_W-1:0]    count,
	output logic                          last
);

	localparam int CW = rfos_pkg::CNT_W;

	logic           mode_q;
	logic [CW-1:0]  capacity_q;
	logic           reg_wr;
	logic           reg_sel;
	logic [CW-1:0]  cap_eff;
	rfos_pkg::cfg_t cfg;
	logic           q_valid;
	logic           q_pop;
	rfos_pkg::cmd_t q_cmd;
	rfos_pkg::res_t res;

	assign pready  = 1'b1;
	assign reg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = paddr[rfos_pkg::ADDR_W-1];

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			capacity_q <= rfos_pkg::CAP_RESET;
		end else if (reg_wr) begin
			unique case (reg_sel)
				rfos_pkg::REG_MODE:     mode_q     <= pwdata[0];
				rfos_pkg::REG_CAPACITY: capacity_q <= pwdata[CW-1:0];
				default: ;
			endcase
		end
	end

	// Register read back
	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			rfos_pkg::REG_MODE:     prdata[0]      = mode_q;
			rfos_pkg::REG_CAPACITY: prdata[CW-1:0] = capacity_q;
			default: ;
		endcase
	end

	// Capacity clamped to 1..DEPTH
	always_comb begin
		if (capacity_q == '0) begin
			cap_eff = CW'(1);
		end else if (capacity_q > rfos_pkg::CAP_RESET) begin
			cap_eff = rfos_pkg::CAP_RESET;
		end else begin
			cap_eff = capacity_q;
		end
	end

	assign cfg.mode  = mode_q;
	assign cfg.cap   = cap_eff;
	assign cfg.clear = reg_wr && (reg_sel == rfos_pkg::REG_CAPACITY);

	rfos_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.data      (data),
		.match_len (match_len),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop)
	);

	rfos_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign status     = res.status;
	assign entry_data = res.data;
	assign position   = res.position;
	assign count      = res.count;
	assign last       = res.last;

endmodule
